// ----- rtl/core/payload_framer_with_delimiters_top_assert.svh -----
// Assertion helpers shared by the framer's RTL.
// Every check is sampled on clk_i and switched off while rst_ni is low.
`ifndef PAYLOAD_FRAMER_WITH_DELIMITERS_TOP_ASSERT_SVH
`define PAYLOAD_FRAMER_WITH_DELIMITERS_TOP_ASSERT_SVH

// Check a property on every rising clock edge.
`define PFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define PFD_NEVER(name, expr, msg) \
  `PFD_ASSERT(name, !(expr), msg)

`endif

// ----- rtl/core/pfd_pkg.sv -----
package pfd_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PLEN_W      = 13;
  localparam int unsigned DELIM_LEN_W = 4;
  localparam int unsigned DELIM_W     = 64;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  // Byte select inside a delimiter word
  localparam int unsigned BSEL_W      = $clog2(DELIM_W / BYTE_W);
  // Result index within one item: start count plus end count fits here
  localparam int unsigned IDX_W       = DELIM_LEN_W + 1;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_DELIM_BYTES = 8;
  localparam int unsigned DEF_MAX_PAYLOAD_LEN = 4096;
  localparam int unsigned DEF_CMD_DEPTH       = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTES   = 3'd4;

  // Reset value of the payload length register
  localparam logic [PLEN_W-1:0] PLEN_RESET = 13'd64;

  // Result byte kinds
  localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;
  } pfd_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] byte_kind;
    logic              run_last;
  } pfd_out_t;

  typedef struct packed {
    logic [PLEN_W-1:0]      payload_len;
    logic [DELIM_LEN_W-1:0] start_len;
    logic [DELIM_W-1:0]     start_bytes;
    logic [DELIM_LEN_W-1:0] end_len;
    logic [DELIM_W-1:0]     end_bytes;
  } pfd_cfg_t;

  // One classified item: payload byte plus the delimiter counts around it
  typedef struct packed {
    logic [BYTE_W-1:0]      data_byte;
    logic [DELIM_LEN_W-1:0] start_cnt;
    logic [DELIM_LEN_W-1:0] end_cnt;
  } pfd_cmd_t;

endpackage

// ----- rtl/core/pfd_front.sv -----
`include "payload_framer_with_delimiters_top_assert.svh"

module pfd_front import pfd_pkg::*; #(
  parameter int unsigned MAX_DELIM_BYTES = DEF_MAX_DELIM_BYTES,
  parameter int unsigned MAX_PAYLOAD_LEN = DEF_MAX_PAYLOAD_LEN
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pfd_cfg_t cfg_i,
  input  logic     push_i,
  input  pfd_in_t  in_i,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output pfd_cmd_t cmd_o
);

  localparam int unsigned PW  = (MAX_PAYLOAD_LEN > 1) ? $clog2(MAX_PAYLOAD_LEN) : 1;
  localparam int unsigned LW0 = $clog2(MAX_PAYLOAD_LEN + 1);
  localparam int unsigned LW  = ((LW0 > PLEN_W) ? LW0 : PLEN_W) + 1;

  logic [PW-1:0]          pos_q, pos_d;
  logic [LW-1:0]          plen_x, flen, pos_next;
  logic                   accept, close;
  logic [DELIM_LEN_W-1:0] start_eff, end_eff;

  assign accept = push_i && !cmd_full_i;

  // Clamp the frame length to 1..MAX_PAYLOAD_LEN
  always_comb begin
    plen_x = LW'(cfg_i.payload_len);
    if (plen_x == '0) begin
      flen = LW'(1);
    end else if (plen_x > LW'(MAX_PAYLOAD_LEN)) begin
      flen = LW'(MAX_PAYLOAD_LEN);
    end else begin
      flen = plen_x;
    end
  end

  assign start_eff = (cfg_i.start_len > DELIM_LEN_W'(MAX_DELIM_BYTES)) ?
                     DELIM_LEN_W'(MAX_DELIM_BYTES) : cfg_i.start_len;
  assign end_eff   = (cfg_i.end_len > DELIM_LEN_W'(MAX_DELIM_BYTES)) ?
                     DELIM_LEN_W'(MAX_DELIM_BYTES) : cfg_i.end_len;

  assign pos_next = LW'(pos_q) + LW'(1);
  // Close the frame on the message's last byte or when it is full
  assign close    = in_i.message_end || (pos_next >= flen);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = close ? '0 : PW'(pos_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    cmd_o.data_byte = in_i.data_byte;
    cmd_o.start_cnt = (pos_q == '0) ? start_eff : '0;
    cmd_o.end_cnt   = close ? end_eff : '0;
  end

  assign cmd_push_o = accept;

  `PFD_ASSERT(a_pos_below_max, pos_q <= PW'(MAX_PAYLOAD_LEN - 1), "frame position out of range")

endmodule

// ----- rtl/core/pfd_fifo.sv -----
`include "payload_framer_with_delimiters_top_assert.svh"

module pfd_fifo import pfd_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CMD_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pfd_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pfd_cmd_t data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pfd_cmd_t        mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `PFD_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count above depth")
  `PFD_NEVER(a_push_full, push_i && full_o, "push into full queue")

endmodule

// ----- rtl/core/pfd_back.sv -----
`include "payload_framer_with_delimiters_top_assert.svh"

module pfd_back import pfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pfd_cfg_t cfg_i,
  input  logic     cmd_valid_i,
  input  pfd_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     empty_o,
  input  logic     pop_i,
  output pfd_out_t out_o
);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  start_x, last_idx, end_off;
  logic              emit, is_last;
  logic              out_valid_q, out_valid_d;
  pfd_out_t          out_q, res;

  // Advance when the output register is free or being drained
  assign emit     = cmd_valid_i && (!out_valid_q || pop_i);
  assign start_x  = IDX_W'(cmd_i.start_cnt);
  assign last_idx = start_x + IDX_W'(cmd_i.end_cnt);
  assign is_last  = (idx_q == last_idx);
  assign end_off  = idx_q - start_x - IDX_W'(1);

  always_comb begin
    res.run_last = is_last;
    if (idx_q < start_x) begin
      res.byte_kind = KIND_START;
      res.out_byte  = cfg_i.start_bytes[{idx_q[BSEL_W-1:0], 3'b000} +: BYTE_W];
    end else if (idx_q == start_x) begin
      res.byte_kind = KIND_PAYLOAD;
      res.out_byte  = cmd_i.data_byte;
    end else begin
      res.byte_kind = KIND_END;
      res.out_byte  = cfg_i.end_bytes[{end_off[BSEL_W-1:0], 3'b000} +: BYTE_W];
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      idx_d       = is_last ? '0 : idx_q + IDX_W'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign cmd_pop_o = emit && is_last;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  `PFD_ASSERT(a_mid_item_head, (idx_q != '0) |-> cmd_valid_i, "head left mid-item")
  `PFD_ASSERT(a_idx_bound, cmd_valid_i |-> (idx_q <= last_idx), "result index past item end")
  `PFD_ASSERT(a_restart, (emit && is_last) |=> (idx_q == '0), "index not cleared after item")

endmodule

// ----- rtl/core/payload_framer_with_delimiters_top.sv -----
// Fixed-length framer: message bytes pushed in are cut into frames of
// payload_len bytes (0 acts as 1, values above MAX_PAYLOAD_LEN are clamped).
// Each frame is preceded by start_len bytes of start_bytes and followed by
// end_len bytes of end_bytes, low byte first, both clamped to
// MAX_DELIM_BYTES. A byte with message_end set also closes the frame, so the
// last frame of a message can be short. Every result carries its kind (start,
// payload, end) and run_last marks the last result of one input byte.
// Rate: one result per clock while results are popped. An input byte yields
// start+1+end results, so plain payload bytes stream at one per cycle and each
// delimiter byte adds one result. A command queue of CMD_DEPTH entries sits
// between classification and emission, so input keeps being taken while
// delimiters go out. The first result of a byte passes through the command
// queue and then the output register before it can be popped.
// Write configuration only while idle; cfg_ready_o is always high and writes
// to unknown indexes are dropped.
`include "payload_framer_with_delimiters_top_assert.svh"

module payload_framer_with_delimiters_top import pfd_pkg::*; #(
  parameter int unsigned MAX_DELIM_BYTES = DEF_MAX_DELIM_BYTES,
  parameter int unsigned MAX_PAYLOAD_LEN = DEF_MAX_PAYLOAD_LEN,
  parameter int unsigned CMD_DEPTH       = DEF_CMD_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input side
  input  logic                 push,
  output logic                 full,
  input  pfd_in_t              in_i,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output pfd_out_t             out_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DELIM_W-1:0]   cfg_data_i
);

  pfd_cfg_t cfg_q, cfg_d;
  logic     cmd_push, cmd_full, cmd_pop, cmd_valid;
  pfd_cmd_t cmd_in, cmd_head;

  // Configuration registers: take a transfer at any index, drop unknown ones
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PAYLOAD_LEN: cfg_d.payload_len = cfg_data_i[PLEN_W-1:0];
        CFG_START_LEN:   cfg_d.start_len   = cfg_data_i[DELIM_LEN_W-1:0];
        CFG_START_BYTES: cfg_d.start_bytes = cfg_data_i;
        CFG_END_LEN:     cfg_d.end_len     = cfg_data_i[DELIM_LEN_W-1:0];
        CFG_END_BYTES:   cfg_d.end_bytes   = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_len <= PLEN_RESET;
      cfg_q.start_len   <= '0;
      cfg_q.start_bytes <= '0;
      cfg_q.end_len     <= '0;
      cfg_q.end_bytes   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: track frame position, decide delimiters around each byte
  pfd_front #(
    .MAX_DELIM_BYTES(MAX_DELIM_BYTES),
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .in_i       (in_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Queue of classified bytes between the two halves
  pfd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  // Back: sequence start delimiter, payload byte, end delimiter
  pfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

  assign full = cmd_full;

  // An item may only be retired while the command queue holds it
  `PFD_NEVER(a_pop_no_item, cmd_pop && !cmd_valid, "item retired from empty queue")
  `PFD_ASSERT(a_cfg_hold, !cfg_valid_i |=> (cfg_q == $past(cfg_q)), "config changed without write")
  `PFD_ASSERT(a_push_takes, (push && !full) |=> !empty || cmd_valid, "accepted byte vanished")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pfd_pkg::*;

  // Run limits: the tail covers the result path plus the command queue, and
  // the cycle cap is many times the slowest correct run.
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PHASE_ITEMS  = 80;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  pfd_in_t              in_i        = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  pfd_out_t             out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DELIM_W-1:0]   cfg_data_i  = '0;

  // Bytes waiting to be offered, and framed bytes predicted but not yet seen.
  pfd_in_t  byte_feed_q[$];
  pfd_out_t framed_q[$];

  // Shadow copy of the framer registers and its frame position.
  logic [PLEN_W-1:0]      shadow_plen   = PLEN_RESET;
  logic [DELIM_LEN_W-1:0] shadow_slen   = '0;
  logic [DELIM_W-1:0]     shadow_sbytes = '0;
  logic [DELIM_LEN_W-1:0] shadow_elen   = '0;
  logic [DELIM_W-1:0]     shadow_ebytes = '0;
  logic [11:0]            frame_pos     = '0;

  // Percent of cycles in which each side holds back.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  payload_framer_with_delimiters_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp a delimiter length the way the framer does.
  function automatic int unsigned delim_bytes(logic [DELIM_LEN_W-1:0] len);
    return (len > DEF_MAX_DELIM_BYTES) ? DEF_MAX_DELIM_BYTES : int'(len);
  endfunction

  // Work out every framed byte that one message byte causes and advance the
  // shadow frame position. run_last goes on the final byte of the run.
  function automatic void frame_message_byte(pfd_in_t item);
    int unsigned flen;
    int unsigned n_start;
    int unsigned n_end;
    int unsigned total;
    int unsigned k;
    bit          closing;
    pfd_out_t    fb;
    if (shadow_plen == 0) flen = 1;
    else if (shadow_plen > DEF_MAX_PAYLOAD_LEN) flen = DEF_MAX_PAYLOAD_LEN;
    else flen = shadow_plen;
    n_start = (frame_pos == 0) ? delim_bytes(shadow_slen) : 0;
    closing = item.message_end || (frame_pos + 32'd1 >= flen);
    n_end   = closing ? delim_bytes(shadow_elen) : 0;
    total   = n_start + 1 + n_end;
    k = 0;
    for (int unsigned b = 0; b < n_start; b++) begin
      k++;
      fb = '{out_byte: shadow_sbytes[8*b +: 8], byte_kind: KIND_START,
             run_last: (k == total)};
      framed_q.push_back(fb);
    end
    k++;
    fb = '{out_byte: item.data_byte, byte_kind: KIND_PAYLOAD, run_last: (k == total)};
    framed_q.push_back(fb);
    for (int unsigned b = 0; b < n_end; b++) begin
      k++;
      fb = '{out_byte: shadow_ebytes[8*b +: 8], byte_kind: KIND_END,
             run_last: (k == total)};
      framed_q.push_back(fb);
    end
    frame_pos = closing ? 12'd0 : frame_pos + 12'd1;
  endfunction

  // Driver: hold the current byte while the framer is full, otherwise offer
  // the next queued byte unless this cycle is an idle one. Predict on every
  // transfer, sampled with the pre-edge values of push and full.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) frame_message_byte(in_i);
      if (!(push && full)) begin
        if (byte_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_i <= byte_feed_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every popped byte against the oldest prediction.
  always @(posedge clk_i) begin
    pfd_out_t want;
    if (rst_ni && pop && !empty) begin
      if (framed_q.size() == 0) begin
        $error("unexpected framed byte %0h kind %0d", out_o.out_byte, out_o.byte_kind);
        mismatch_cnt++;
      end else begin
        want = framed_q.pop_front();
        if (out_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_o.out_byte);
          mismatch_cnt++;
        end
        if (out_o.byte_kind !== want.byte_kind) begin
          $error("byte_kind: expected %0d, got %0d", want.byte_kind, out_o.byte_kind);
          mismatch_cnt++;
        end
        if (out_o.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_o.run_last);
          mismatch_cnt++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void queue_byte(logic [BYTE_W-1:0] b, logic last);
    pfd_in_t item;
    item.data_byte   = b;
    item.message_end = last;
    byte_feed_q.push_back(item);
  endfunction

  // Queue one well-formed message: random bytes, end flag on the final one.
  function automatic int unsigned queue_message(int unsigned len);
    for (int unsigned n = 0; n < len; n++) queue_byte(8'($urandom), n == len - 1);
    return len;
  endfunction

  // Wait until every queued byte is transferred and every framed byte has
  // come back, then let the framer settle.
  task automatic wait_frames_drained();
    do @(posedge clk_i);
    while (byte_feed_q.size() != 0 || push || framed_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // One register transfer; valid stays high for a following write and the
  // caller drops it after the last one. Mirror the write into the shadow.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DELIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PAYLOAD_LEN: shadow_plen   = val[PLEN_W-1:0];
      CFG_START_LEN:   shadow_slen   = val[DELIM_LEN_W-1:0];
      CFG_START_BYTES: shadow_sbytes = val;
      CFG_END_LEN:     shadow_elen   = val[DELIM_LEN_W-1:0];
      CFG_END_BYTES:   shadow_ebytes = val;
      default: ;
    endcase
  endtask

  function automatic logic [DELIM_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Pick a fresh setup: mostly short frames so frames close often, now and
  // then a zero, maximal or oversized payload length.
  task automatic write_random_setup();
    logic [PLEN_W-1:0] plen_pick;
    case ($urandom_range(9))
      0:       plen_pick = '0;
      1:       plen_pick = PLEN_W'(DEF_MAX_PAYLOAD_LEN);
      2:       plen_pick = PLEN_W'($urandom_range(DEF_MAX_PAYLOAD_LEN + 1, 8191));
      default: plen_pick = PLEN_W'($urandom_range(1, 12));
    endcase
    cfg_write(CFG_PAYLOAD_LEN, {$urandom, 19'($urandom), plen_pick});
    cfg_write(CFG_START_LEN, rand_word());
    cfg_write(CFG_START_BYTES, rand_word());
    cfg_write(CFG_END_LEN, rand_word());
    cfg_write(CFG_END_BYTES, rand_word());
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly whole messages, some stray bytes with a random
  // end flag. Optionally pause halfway until every framed byte is back.
  task automatic run_random_phase(bit pause_midway);
    int unsigned queued;
    bit          paused;
    queued = 0;
    paused = 0;
    while (queued < PHASE_ITEMS) begin
      if ($urandom_range(99) < 85)
        queued += queue_message(($urandom_range(4) == 0) ? $urandom_range(1, 40)
                                                         : $urandom_range(1, 8));
      else begin
        queue_byte(8'($urandom), 1'($urandom));
        queued++;
      end
      if (pause_midway && !paused && queued >= PHASE_ITEMS / 2) begin
        wait_frames_drained();
        paused = 1;
      end
    end
    wait_frames_drained();
  endtask

  initial begin
    logic [DELIM_W-1:0] unused_sink;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setup: 64-byte frames, no delimiters; extreme byte values.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b1);
    wait_frames_drained();

    // Zero payload length acts as one; oversized delimiter lengths clamp to
    // eight, so each byte yields the longest run. Writes to unknown indexes
    // must change nothing.
    cfg_write(CFG_PAYLOAD_LEN, '0);
    cfg_write(CFG_START_LEN, 64'd15);
    cfg_write(CFG_START_BYTES, '1);
    cfg_write(CFG_END_LEN, 64'd9);
    cfg_write(CFG_END_BYTES, rand_word());
    for (int unsigned i = int'(CFG_END_BYTES) + 1; i < 2 ** CFG_IDX_W; i++) begin
      unused_sink = '1;
      cfg_write(CFG_IDX_W'(i), unused_sink);
    end
    cfg_valid_i <= 1'b0;
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_frames_drained();

    // Short frames: a five-byte message cut into a full and a short frame.
    cfg_write(CFG_PAYLOAD_LEN, 64'd3);
    cfg_write(CFG_START_LEN, 64'd2);
    cfg_write(CFG_START_BYTES, rand_word());
    cfg_write(CFG_END_LEN, 64'd1);
    cfg_valid_i <= 1'b0;
    void'(queue_message(5));
    wait_frames_drained();

    // Lower the length below the current position mid-frame: the next byte
    // must close the frame.
    cfg_write(CFG_PAYLOAD_LEN, 64'd8);
    cfg_valid_i <= 1'b0;
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h01, 1'b0);
    wait_frames_drained();
    cfg_write(CFG_PAYLOAD_LEN, 64'd2);
    cfg_valid_i <= 1'b0;
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    wait_frames_drained();

    // Oversized payload length clamps to the maximum; no start delimiter,
    // full-length end delimiter.
    cfg_write(CFG_PAYLOAD_LEN, 64'h1FFF);
    cfg_write(CFG_START_LEN, '0);
    cfg_write(CFG_END_LEN, 64'd8);
    cfg_write(CFG_END_BYTES, '0);
    cfg_valid_i <= 1'b0;
    void'(queue_message(3));
    wait_frames_drained();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 30; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int unsigned setup = 0; setup < 2; setup++) begin
        write_random_setup();
        run_random_phase(mode == 0 && setup == 0);
      end
    end

    if (mismatch_cnt == 0 && framed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- payload_framer_with_delimiters_top.f -----
+incdir+rtl/core
rtl/core/pfd_pkg.sv
rtl/core/pfd_front.sv
rtl/core/pfd_fifo.sv
rtl/core/pfd_back.sv
rtl/core/payload_framer_with_delimiters_top.sv
sim/tb_top.sv
